[hdl/bsm_pkg.sv]
package bsm_pkg;

    localparam logic [2:0] CASE_DEGEN  = 3'd0;
    localparam logic [2:0] CASE_IN_IN  = 3'd1;
    localparam logic [2:0] CASE_ACC_IN = 3'd2;
    localparam logic [2:0] CASE_MERGED = 3'd3;
    localparam logic [2:0] CASE_LOADED = 3'd4;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    // controller commands to the datapath
    typedef struct packed {
        logic load_in;    // latch input item
        logic sq_step;    // accumulate one squared axis
        logic sqrt_init;
        logic sqrt_step;
        logic decide;     // resolve the case from d
        logic div_init;   // start one axis division
        logic div_step;
        logic div_done;   // write the moved axis
        logic [1:0] axis;
        logic commit;     // write accumulator and result
    } t_cmd;

    typedef struct packed {
        logic merge;      // decide chose the merged case
    } t_status;

endpackage

[hdl/bsm_datapath.sv]
module bsm_datapath #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsm_pkg::t_cmd                 i_cmd,
    output bsm_pkg::t_status              o_status,
    input  logic [15:0]                   i_threshold,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_in_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_center_z,
    input  logic [COORD_WIDTH-2:0]        i_in_radius,
    output logic signed [COORD_WIDTH-1:0] o_out_center_x,
    output logic signed [COORD_WIDTH-1:0] o_out_center_y,
    output logic signed [COORD_WIDTH-1:0] o_out_center_z,
    output logic [COORD_WIDTH-2:0]        o_out_radius,
    output logic [2:0]                    o_merge_case
);
    import bsm_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int SW = 2 * CW + 4;       // sum of three squares
    localparam int DW = CW + 2;           // distance width
    localparam int PW = 2 * CW + 2;       // coef * delta product

    logic                 r_mode;
    logic signed [CW-1:0] r_in [3];
    logic [CW-2:0]        r_r1;
    logic signed [CW-1:0] r_acc [3];
    logic [CW-2:0]        r_r0;
    logic [SW-1:0]        r_sum;
    logic [DW-1:0]        r_d;
    logic [2:0]           r_case;
    logic                 r_take_in;
    // sqrt state
    logic [SW-1:0]        r_rad;
    logic [DW+1:0]        r_rem;
    logic [DW-1:0]        r_root;
    // divide state
    logic [PW-1:0]        r_num;
    logic [DW-1:0]        r_drem;
    logic [PW-1:0]        r_quo;
    logic                 r_neg;

    logic [CW:0]          w_delta [3];
    logic [CW:0]          w_dax;
    logic [DW+1:0]        w_trial;
    logic [DW+1:0]        w_rsh;
    logic [DW:0]          w_dsh;
    logic [DW+1:0]        w_dpr0;
    logic [DW+1:0]        w_dpr1;
    logic signed [CW+1:0] w_moved;
    logic [DW:0]          w_sum01;
    logic [DW:0]          w_rad;
    logic [DW:0]          w_cf;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_delta[a] = (r_in[a] >= r_acc[a])
                ? ({r_in[a][CW-1], r_in[a]} - {r_acc[a][CW-1], r_acc[a]})
                : ({r_acc[a][CW-1], r_acc[a]} - {r_in[a][CW-1], r_in[a]});
        end
        w_dax   = w_delta[i_cmd.axis];
        // bitwise sqrt: two bits of the radicand per step
        w_rsh   = {r_rem[DW-1:0], r_rad[SW-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_dsh   = {r_drem, r_num[PW-1]};
        w_dpr0  = {2'b00, r_d};
        w_dpr1  = {1'b0, w_dsh};
        w_moved = r_neg ? ($signed({{2{r_acc[i_cmd.axis][CW-1]}}, r_acc[i_cmd.axis]})
                           - $signed({2'b00, r_quo[CW-1:0]}))
                        : ($signed({{2{r_acc[i_cmd.axis][CW-1]}}, r_acc[i_cmd.axis]})
                           + $signed({2'b00, r_quo[CW-1:0]}));
        w_sum01 = {1'b0, r_d} + DW'(r_r0) + DW'(r_r1);
        w_rad   = w_sum01 >> 1;
        w_cf    = ({1'b0, r_d} + DW'(r_r1) - DW'(r_r0)) >> 1;
    end

    assign o_status.merge = (r_case == CASE_MERGED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) r_acc[a] <= '0;
            r_r0 <= '0;
            r_case <= CASE_DEGEN;
        end else begin
            if (i_cmd.load_in) begin
                r_mode <= i_mode;
                r_in[0] <= i_in_center_x;
                r_in[1] <= i_in_center_y;
                r_in[2] <= i_in_center_z;
                r_r1 <= i_in_radius;
                r_sum <= '0;
            end
            if (i_cmd.sq_step) begin
                r_sum <= r_sum + SW'(w_dax * w_dax);
            end
            if (i_cmd.sqrt_init) begin
                r_rad  <= r_sum;
                r_rem  <= '0;
                r_root <= '0;
            end
            if (i_cmd.sqrt_step) begin
                r_rad <= r_rad << 2;
                if (w_rsh >= w_trial) begin
                    r_rem  <= w_rsh - w_trial;
                    r_root <= {r_root[DW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rsh;
                    r_root <= {r_root[DW-2:0], 1'b0};
                end
            end
            if (i_cmd.decide) begin
                r_d <= r_root;
                if (r_mode) begin
                    r_case <= CASE_LOADED;
                    r_take_in <= 1'b1;
                end else if (r_root <= DW'(i_threshold) || r_r0 == '0 || r_r1 == '0) begin
                    r_case <= CASE_DEGEN;
                    r_take_in <= (r_r1 > r_r0);
                end else if ((DW+1)'(r_r0) > {1'b0, r_root} + (DW+1)'(r_r1)) begin
                    r_case <= CASE_IN_IN;
                    r_take_in <= 1'b0;
                end else if ((DW+1)'(r_r1) > {1'b0, r_root} + (DW+1)'(r_r0)) begin
                    r_case <= CASE_ACC_IN;
                    r_take_in <= 1'b1;
                end else begin
                    r_case <= CASE_MERGED;
                    r_take_in <= 1'b0;
                end
            end
            if (i_cmd.div_init) begin
                r_num  <= PW'(w_cf[DW-1:0] * w_dax);
                r_neg  <= (r_in[i_cmd.axis] < r_acc[i_cmd.axis]);
                r_drem <= '0;
                r_quo  <= '0;
            end
            if (i_cmd.div_step) begin
                r_num <= r_num << 1;
                if (w_dpr1 >= w_dpr0) begin
                    r_drem <= DW'(w_dpr1 - w_dpr0);
                    r_quo  <= {r_quo[PW-2:0], 1'b1};
                end else begin
                    r_drem <= w_dsh[DW-1:0];
                    r_quo  <= {r_quo[PW-2:0], 1'b0};
                end
            end
            if (i_cmd.div_done) begin
                r_acc[i_cmd.axis] <= CW'(w_moved);
            end
            if (i_cmd.commit) begin
                if (r_take_in) begin
                    r_acc[0] <= r_in[0];
                    r_acc[1] <= r_in[1];
                    r_acc[2] <= r_in[2];
                    r_r0 <= r_r1;
                end else if (r_case == CASE_MERGED) begin
                    r_r0 <= (w_rad > (DW+1)'({(CW-1){1'b1}})) ? '1 : (CW-1)'(w_rad);
                end
            end
        end
    end

    assign o_out_center_x = r_acc[0];
    assign o_out_center_y = r_acc[1];
    assign o_out_center_z = r_acc[2];
    assign o_out_radius   = r_r0;
    assign o_merge_case   = r_case;

endmodule

[hdl/bsm_ctrl.sv]
module bsm_ctrl #(
    parameter int COORD_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  bsm_pkg::t_status i_status,
    output bsm_pkg::t_cmd    o_cmd
);
    import bsm_pkg::*;

    localparam int SQ_STEPS  = COORD_WIDTH + 2;
    localparam int DIV_STEPS = 2 * COORD_WIDTH + 2;
    localparam int CNTW = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_DIVI = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_COM  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [1:0]      r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_SQ;
                    n_axis  = 2'd0;
                end
            end
            ST_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (r_axis == 2'd2) begin
                    n_state = ST_SQRT;
                    n_cnt   = '0;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            ST_SQRT: begin
                if (r_cnt == '0) o_cmd.sqrt_init = 1'b1;
                else o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(SQ_STEPS)) n_state = ST_DEC;
            end
            ST_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = ST_COM;
            end
            ST_COM: begin
                if (i_status.merge) begin
                    n_state = ST_DIVI;
                    n_axis  = 2'd0;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(DIV_STEPS)) begin
                    o_cmd.div_done = 1'b1;
                    if (r_axis == 2'd2) begin
                        o_cmd.commit = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = ST_DIVI;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_cmd.commit)) else $error("result without commit");
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != 2'd3) else $error("axis out of range");

endmodule

[hdl/bounding_sphere_merge.sv]
// Keeps a running bounding sphere and merges one sphere per transfer, or loads
// it when mode is 1. After the input transfer the block sums the squared deltas,
// runs the bit-serial square root and picks the case; in the merged case three
// bit-serial divisions follow. The result is held until taken, and the next input
// is accepted the cycle after the result transfer, not while an item is in
// progress; the square root and divider step in series.
module bounding_sphere_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic signed [COORD_WIDTH-1:0] i_in_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_center_z,
    input  logic [COORD_WIDTH-2:0]        i_in_radius,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_center_x,
    output logic signed [COORD_WIDTH-1:0] o_out_center_y,
    output logic signed [COORD_WIDTH-1:0] o_out_center_z,
    output logic [COORD_WIDTH-2:0]        o_out_radius,
    output logic [2:0]                    o_merge_case
);
    import bsm_pkg::*;

    logic [15:0] r_threshold;
    t_cmd        w_cmd;
    t_status     w_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'd66;
        end else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
            r_threshold <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, r_threshold} : 32'd0;

    bsm_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .o_valid, .i_ready,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    bsm_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd), .o_status(w_status), .i_threshold(r_threshold),
        .i_mode, .i_in_center_x, .i_in_center_y, .i_in_center_z, .i_in_radius,
        .o_out_center_x, .o_out_center_y, .o_out_center_z, .o_out_radius,
        .o_merge_case
    );

    logic unused_ok;
    assign unused_ok = ^{paddr[1:0], pwdata[31:16]};

endmodule
